>>> hdl/assert_macros.svh
// assertion macros used by periodic_timer_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition never holds
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`define ASSERT_NEVER(name, cond, msg)

`endif

`endif

>>> hdl/ptt_pkg.sv
// types and constants of the periodic timer table
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TIMER_SLOTS_DEF  = 16;
    localparam int HANDLE_COUNT_DEF = 256;

    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 32;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_QUERY  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_ADDED       = 4'd0,
        ST_REMOVED     = 4'd1,
        ST_FIRED       = 4'd2,
        ST_NONE_FIRED  = 4'd3,
        ST_DEADLINE    = 4'd4,
        ST_NO_DEADLINE = 4'd5,
        ST_FULL        = 4'd6,
        ST_NOT_PRESENT = 4'd7,
        ST_DUPLICATE   = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HCHECK,
        S_MOVE,
        S_WALK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   period;
        logic [HANDLE_W-1:0] owner;
    } slot_entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_present;
    } hdir_ctl_t;

endpackage

>>> hdl/ptt_hdir.sv
// handle directory: present bit and slot position per handle, cleared after reset
`timescale 1ns / 1ps

module ptt_hdir
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS  = TIMER_SLOTS_DEF,
    parameter int HANDLE_COUNT = HANDLE_COUNT_DEF,
    localparam int SIDX_W = $clog2(TIMER_SLOTS),
    localparam int HIDX_W = $clog2(HANDLE_COUNT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hdir_ctl_t         ctl,
    input  logic [HIDX_W-1:0] rd_addr,
    input  logic [HIDX_W-1:0] wr_addr,
    input  logic [SIDX_W-1:0] wr_pos,
    output logic              rd_present,
    output logic [SIDX_W-1:0] rd_pos,
    output logic              busy
);

    localparam logic [HIDX_W-1:0] LAST_IDX = HIDX_W'(HANDLE_COUNT - 1);

    logic              clr_reg;
    logic              clr_next;
    logic [HIDX_W-1:0] clr_idx_reg;
    logic [HIDX_W-1:0] clr_idx_next;

    logic [SIDX_W:0]   mem [HANDLE_COUNT];
    logic [SIDX_W:0]   rd_data_reg;

    logic              we;
    logic [HIDX_W-1:0] waddr;
    logic [SIDX_W:0]   wdata;

    // clearing pass owns the write port until every entry is zero
    always_comb
    begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            we           = 1'b1;
            waddr        = clr_idx_reg;
            wdata        = '0;
            clr_idx_next = clr_idx_reg + HIDX_W'(1);
            clr_next     = (clr_idx_reg != LAST_IDX);
        end
        else
        begin
            we    = ctl.wr_en;
            waddr = wr_addr;
            wdata = {ctl.wr_present, wr_pos};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_present = rd_data_reg[SIDX_W];
    assign rd_pos     = rd_data_reg[SIDX_W-1:0];
    assign busy       = clr_reg;

endmodule

>>> hdl/periodic_timer_table.sv
// top level of the periodic timer table
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   | direction | transaction payload
// ----------+-----------+---------------------------------------------------------
// s_*       | in        | tuser: req_type; tdata: timer_handle, period_ms, now_ms
// m_*       | out       | tuser: status; tdata: result_handle, remaining_ms; tlast: last
//
// add and delete run accept, directory lookup, result; delete adds a move step when
// the last slot moves into the hole; tick and query walk the active slots (an empty
// table goes straight to the final result), one slot per cycle through the slot memory
// read port unless frozen as below, in a 3-stage read / elapsed / evaluate pipe
// after reset the handle directory is swept to zero with s_tready low
// a stalled result register freezes a tick walk only when a second fire must be handed
// off; add, delete and the final result wait on it; one request is in work at a time

module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS  = TIMER_SLOTS_DEF,
    parameter int HANDLE_COUNT = HANDLE_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_handle[7:0], period_ms[39:8], now_ms[71:40]
    input  logic [1:0]  s_tuser,   // req_type[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_handle[7:0], remaining_ms[39:8]
    output logic [3:0]  m_tuser,   // status[3:0]
    output logic        m_tlast    // final result of the request
);

    localparam int SIDX_W = $clog2(TIMER_SLOTS);
    localparam int HIDX_W = $clog2(HANDLE_COUNT);
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

    // input unpack
    logic [HANDLE_W-1:0] in_handle;
    logic [TIME_W-1:0]   in_period;
    logic [TIME_W-1:0]   in_now;
    req_t                in_req;
    logic                in_range_in;
    logic                accept;

    assign in_handle   = s_tdata[7:0];
    assign in_period   = s_tdata[39:8];
    assign in_now      = s_tdata[71:40];
    assign in_req      = req_t'(s_tuser);
    assign in_range_in = (32'(in_handle) < 32'(HANDLE_COUNT));

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  iss_idx_reg, iss_idx_next;
    logic              d_valid_reg, d_valid_next;
    logic              e_valid_reg, e_valid_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              found_reg, found_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // request and walk payload
    req_t                req_reg, req_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [TIME_W-1:0]   period_reg, period_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SIDX_W-1:0]   pos_reg, pos_next;
    logic [SIDX_W-1:0]   d_idx_reg, d_idx_next;
    logic [SIDX_W-1:0]   e_idx_reg, e_idx_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   e_period_reg, e_period_next;
    logic [HANDLE_W-1:0] e_owner_reg, e_owner_next;
    logic [HANDLE_W-1:0] pend_owner_reg, pend_owner_next;
    logic [TIME_W-1:0]   best_reg, best_next;

    // result register
    status_t             status_reg, status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic                last_reg, last_next;
    logic                out_load;
    logic                out_full;

    // slot memory
    slot_entry_t         slot_mem [TIMER_SLOTS];
    slot_entry_t         slot_rd_reg;
    logic                slot_re;
    logic [SIDX_W-1:0]   slot_raddr;
    logic                slot_we;
    logic [SIDX_W-1:0]   slot_waddr;
    slot_entry_t         slot_wdata;

    // handle directory
    hdir_ctl_t           hdir_ctl;
    logic [HIDX_W-1:0]   hdir_rd_addr;
    logic [HIDX_W-1:0]   hdir_wr_addr;
    logic [SIDX_W-1:0]   hdir_wr_pos;
    logic                hdir_present;
    logic [SIDX_W-1:0]   hdir_pos;
    logic                hdir_busy;

    // decisions after the directory lookup
    logic                h_in_range;
    logic                table_full;
    logic                add_ok;
    logic                add_commit;
    logic                del_ok;
    logic                del_move;
    logic [CNT_W-1:0]    last_pos;

    // walk pipeline
    logic                is_tick;
    logic                e_fire;
    logic                e_pending;
    logic [TIME_W-1:0]   e_rem;
    logic                e_last;
    logic                iss_more;
    logic                walk_stall;
    logic                walk_adv;

    ptt_hdir #(
        .TIMER_SLOTS  (TIMER_SLOTS),
        .HANDLE_COUNT (HANDLE_COUNT)
    ) u_hdir (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (hdir_ctl),
        .rd_addr    (hdir_rd_addr),
        .wr_addr    (hdir_wr_addr),
        .wr_pos     (hdir_wr_pos),
        .rd_present (hdir_present),
        .rd_pos     (hdir_pos),
        .busy       (hdir_busy)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_full = m_tvalid_reg && !m_tready;

    assign h_in_range = (32'(handle_reg) < 32'(HANDLE_COUNT));
    assign table_full = (count_reg == CNT_W'(TIMER_SLOTS));
    assign last_pos   = count_reg - CNT_W'(1);
    assign add_ok     = h_in_range && !hdir_present && !table_full;
    assign del_ok     = h_in_range && hdir_present;
    assign del_move   = (CNT_W'(hdir_pos) < last_pos);

    // elapsed is registered one stage ahead so the evaluate stage has one sub and compare
    assign is_tick    = (req_reg == REQ_TICK);
    assign e_fire     = e_valid_reg && (elapsed_reg > e_period_reg);
    assign e_pending  = e_valid_reg && (elapsed_reg < e_period_reg);
    assign e_rem      = e_period_reg - elapsed_reg;
    assign e_last     = e_valid_reg && (CNT_W'(e_idx_reg) == last_pos);
    assign iss_more   = (iss_idx_reg < count_reg);
    // a second fire needs the result register to hand off the one held back
    assign walk_stall = is_tick && e_fire && pend_valid_reg && out_full;
    assign walk_adv   = (state_reg == S_WALK) && !walk_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (!hdir_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == REQ_ADD || in_req == REQ_DELETE)
                    begin
                        state_next = S_HCHECK;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_HCHECK:
            begin
                if (req_reg == REQ_DELETE && del_ok && del_move)
                begin
                    state_next = S_MOVE;
                end
                else if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOVE:
            begin
                if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (walk_adv && e_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        count_next      = count_reg;
        iss_idx_next    = iss_idx_reg;
        d_valid_next    = d_valid_reg;
        e_valid_next    = e_valid_reg;
        pend_valid_next = pend_valid_reg;
        found_next      = found_reg;
        req_next        = req_reg;
        handle_next     = handle_reg;
        period_next     = period_reg;
        now_next        = now_reg;
        pos_next        = pos_reg;
        d_idx_next      = d_idx_reg;
        e_idx_next      = e_idx_reg;
        elapsed_next    = elapsed_reg;
        e_period_next   = e_period_reg;
        e_owner_next    = e_owner_reg;
        pend_owner_next = pend_owner_reg;
        best_next       = best_reg;

        out_load        = 1'b0;
        status_next     = status_reg;
        res_handle_next = res_handle_reg;
        rem_next        = rem_reg;
        last_next       = last_reg;

        slot_re         = 1'b0;
        slot_raddr      = iss_idx_reg[SIDX_W-1:0];
        slot_we         = 1'b0;
        slot_waddr      = e_idx_reg;
        slot_wdata      = '{start: now_reg, period: e_period_reg, owner: e_owner_reg};

        hdir_ctl        = '{rd_en: 1'b0, wr_en: 1'b0, wr_present: 1'b0};
        hdir_rd_addr    = HIDX_W'(in_handle);
        hdir_wr_addr    = HIDX_W'(handle_reg);
        hdir_wr_pos     = count_reg[SIDX_W-1:0];
        add_commit      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = in_req;
                    handle_next     = in_handle;
                    period_next     = in_period;
                    now_next        = in_now;
                    iss_idx_next    = '0;
                    d_valid_next    = 1'b0;
                    e_valid_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    found_next      = 1'b0;
                    best_next       = '0;
                    // look up the handle; out-of-range handles skip the lookup
                    hdir_ctl.rd_en  = (in_req == REQ_ADD || in_req == REQ_DELETE) &&
                                      in_range_in;
                end
            end
            S_HCHECK:
            begin
                if (req_reg == REQ_ADD)
                begin
                    if (!out_full)
                    begin
                        out_load        = 1'b1;
                        res_handle_next = handle_reg;
                        rem_next        = '0;
                        last_next       = 1'b1;
                        if (!h_in_range)
                        begin
                            status_next = ST_NOT_PRESENT;
                        end
                        else if (hdir_present)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else if (table_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_ADDED;
                        end
                        if (add_ok)
                        begin
                            add_commit          = 1'b1;
                            slot_we             = 1'b1;
                            slot_waddr          = count_reg[SIDX_W-1:0];
                            slot_wdata          = '{start: now_reg, period: period_reg,
                                                    owner: handle_reg};
                            hdir_ctl.wr_en      = 1'b1;
                            hdir_ctl.wr_present = 1'b1;
                            hdir_wr_pos         = count_reg[SIDX_W-1:0];
                            count_next          = count_reg + CNT_W'(1);
                        end
                    end
                end
                else if (del_ok && del_move)
                begin
                    // free the handle now, fetch the last slot to fill the hole
                    hdir_ctl.wr_en = 1'b1;
                    slot_re        = 1'b1;
                    slot_raddr     = last_pos[SIDX_W-1:0];
                    pos_next       = hdir_pos;
                end
                else if (!out_full)
                begin
                    out_load        = 1'b1;
                    res_handle_next = handle_reg;
                    rem_next        = '0;
                    last_next       = 1'b1;
                    if (del_ok)
                    begin
                        status_next    = ST_REMOVED;
                        hdir_ctl.wr_en = 1'b1;
                        count_next     = last_pos;
                    end
                    else
                    begin
                        status_next = ST_NOT_PRESENT;
                    end
                end
            end
            S_MOVE:
            begin
                if (!out_full)
                begin
                    slot_we             = 1'b1;
                    slot_waddr          = pos_reg;
                    slot_wdata          = slot_rd_reg;
                    hdir_ctl.wr_en      = 1'b1;
                    hdir_ctl.wr_present = 1'b1;
                    hdir_wr_addr        = HIDX_W'(slot_rd_reg.owner);
                    hdir_wr_pos         = pos_reg;
                    count_next          = last_pos;
                    out_load            = 1'b1;
                    status_next         = ST_REMOVED;
                    res_handle_next     = handle_reg;
                    rem_next            = '0;
                    last_next           = 1'b1;
                end
            end
            S_WALK:
            begin
                if (walk_adv)
                begin
                    // read stage
                    if (iss_more)
                    begin
                        slot_re      = 1'b1;
                        iss_idx_next = iss_idx_reg + CNT_W'(1);
                        d_valid_next = 1'b1;
                        d_idx_next   = iss_idx_reg[SIDX_W-1:0];
                    end
                    else
                    begin
                        d_valid_next = 1'b0;
                    end
                    // elapsed stage
                    e_valid_next = d_valid_reg;
                    if (d_valid_reg)
                    begin
                        elapsed_next  = now_reg - slot_rd_reg.start;
                        e_period_next = slot_rd_reg.period;
                        e_owner_next  = slot_rd_reg.owner;
                        e_idx_next    = d_idx_reg;
                    end
                    // evaluate stage
                    if (is_tick)
                    begin
                        if (e_fire)
                        begin
                            slot_we = 1'b1;
                            // hold the newest fire back until its last flag is known
                            if (pend_valid_reg)
                            begin
                                out_load        = 1'b1;
                                status_next     = ST_FIRED;
                                res_handle_next = pend_owner_reg;
                                rem_next        = '0;
                                last_next       = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_owner_next = e_owner_reg;
                        end
                    end
                    else if (e_pending && (!found_reg || e_rem < best_reg))
                    begin
                        best_next  = e_rem;
                        found_next = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_full)
                begin
                    out_load  = 1'b1;
                    last_next = 1'b1;
                    rem_next  = '0;
                    res_handle_next = '0;
                    if (is_tick)
                    begin
                        if (pend_valid_reg)
                        begin
                            status_next     = ST_FIRED;
                            res_handle_next = pend_owner_reg;
                        end
                        else
                        begin
                            status_next = ST_NONE_FIRED;
                        end
                    end
                    else if (found_reg)
                    begin
                        status_next = ST_DEADLINE;
                        rem_next    = best_reg;
                    end
                    else
                    begin
                        status_next = ST_NO_DEADLINE;
                    end
                end
            end
            default:
            begin
            end
        endcase

        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            count_reg      <= '0;
            iss_idx_reg    <= '0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            iss_idx_reg    <= iss_idx_next;
            d_valid_reg    <= d_valid_next;
            e_valid_reg    <= e_valid_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        handle_reg     <= handle_next;
        period_reg     <= period_next;
        now_reg        <= now_next;
        pos_reg        <= pos_next;
        d_idx_reg      <= d_idx_next;
        e_idx_reg      <= e_idx_next;
        elapsed_reg    <= elapsed_next;
        e_period_reg   <= e_period_next;
        e_owner_reg    <= e_owner_next;
        pend_owner_reg <= pend_owner_next;
        best_reg       <= best_next;
        status_reg     <= status_next;
        res_handle_reg <= res_handle_next;
        rem_reg        <= rem_next;
        last_reg       <= last_next;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {rem_reg, res_handle_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(TIMER_SLOTS), "active count above slot count")
    `ASSERT_NEVER(a_out_overwrite, out_load && out_full, "result register overwritten while held")
    `ASSERT_NEXT(a_add_grows, add_commit, count_reg == $past(count_reg) + CNT_W'(1), "add lost")
    `ASSERT_IMPLY(a_walk_index, e_valid_reg && state_reg == S_WALK, CNT_W'(e_idx_reg) < count_reg, "walk past active slots")
    `ASSERT_IMPLY(a_clear_blocks, hdir_busy, !s_tready, "request taken during directory clear")

endmodule
